// ----- rtl/rational_arithmetic_unit_core_defines.svh -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit: assertion macros
// Concurrent check wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define RAU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: check failed");

`define RAU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");

`else

`define RAU_ASSERT(lbl, clk, rst_n, prop)

`define RAU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/rau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, action codes and ALU operation codes.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int OPERAND_BITS_DEF = 16;
	localparam int NUM_OUT_BITS     = 33;
	localparam int DEN_OUT_BITS     = 32;

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_MUL = 2'd2,
		ACT_DIV = 2'd3
	} action_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

endpackage

// ----- rtl/rau_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit request channel
// Valid/ready channel carrying the action and the two operand fractions.
// ----------------------------------------------------------------------------
interface rau_in_if #(
	parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
);
	logic                           valid;
	logic                           ready;
	logic [1:0]                     action;
	logic signed [OPERAND_BITS-1:0] a_numerator;
	logic signed [OPERAND_BITS-1:0] a_denominator;
	logic signed [OPERAND_BITS-1:0] b_numerator;
	logic signed [OPERAND_BITS-1:0] b_denominator;

	modport source (
		output valid, action, a_numerator, a_denominator, b_numerator, b_denominator,
		input  ready
	);

	modport sink (
		input  valid, action, a_numerator, a_denominator, b_numerator, b_denominator,
		output ready
	);
endinterface

// ----- rtl/rau_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit response channel
// Valid/ready channel carrying the reduced fraction and its status.
// ----------------------------------------------------------------------------
interface rau_out_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [rau_pkg::NUM_OUT_BITS-1:0] result_numerator;
	logic [rau_pkg::DEN_OUT_BITS-1:0]        result_denominator;
	logic                                    status;

	modport source (
		output valid, result_numerator, result_denominator, status,
		input  ready
	);

	modport sink (
		input  valid, result_numerator, result_denominator, status,
		output ready
	);
endinterface

// ----- rtl/rau_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit shared adder
// Single add/subtract unit used for sums, negation, compare and division.
// ----------------------------------------------------------------------------
module rau_alu #(
	parameter int WIDTH = 2 * rau_pkg::OPERAND_BITS_DEF + 1
) (
	input  rau_pkg::alu_op_t   op,
	input  logic [WIDTH-1:0]   a,
	input  logic [WIDTH-1:0]   b,
	output logic [WIDTH-1:0]   res
);

	always_comb begin
		unique case (op)
			rau_pkg::ALU_ADD: res = a + b;
			rau_pkg::ALU_SUB: res = a - b;
			default:          res = a - b;
		endcase
	end

endmodule

// ----- rtl/rau_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit multiplier
// Signed operand multiplier with a registered product.
// ----------------------------------------------------------------------------
module rau_mul #(
	parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
	input  logic                             clk,
	input  logic signed [OPERAND_BITS-1:0]   a,
	input  logic signed [OPERAND_BITS-1:0]   b,
	output logic signed [2*OPERAND_BITS-1:0] p_s1
);

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule

// ----- rtl/rational_arithmetic_unit_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit core
// Adds, subtracts, multiplies or divides two signed fractions and returns the
// result reduced to lowest terms with a positive denominator.
//
// req carries the action and a = a_numerator / a_denominator, b likewise; rsp
// returns result_numerator / result_denominator and status (1 on a zero
// denominator or an out-of-range result, with both result fields zero).
// One request is in work at a time: req.ready is high only while idle.
// Sequence: multiplier states MUL0 to MUL3, setup states CHK, MAGN and MAGD,
// a binary GCD on the shared adder, GSHL to restore the common factors of
// two, restoring divisions of numerator and denominator by the GCD (DIVN,
// DIVD) and the output state FIN. Error and zero results go from CHK straight
// to FIN. The shared adder sets the pace.
// The finished result sits in an output register; the next request is taken
// while it waits, and the core stalls in its last step if rsp is still full.
// Reset clears the sequencer and drops any pending result.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_core_defines.svh"

module rational_arithmetic_unit_core #(
	parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rau_in_if.sink    req,
	rau_out_if.source rsp
);

	localparam int OB  = OPERAND_BITS;
	localparam int PW  = 2 * OB;
	localparam int MW  = 2 * OB;
	localparam int AW  = MW + 1;
	localparam int CNW = $clog2(MW + 1);
	localparam int NOB = rau_pkg::NUM_OUT_BITS;
	localparam int DOB = rau_pkg::DEN_OUT_BITS;
	localparam int XW  = (MW > NOB) ? MW + 1 : NOB + 1;

	localparam logic [XW-1:0] DEN_LIM = {{(XW-DOB){1'b0}}, {DOB{1'b1}}};
	localparam logic [XW-1:0] POS_LIM = {{(XW-NOB+1){1'b0}}, {(NOB-1){1'b1}}};
	localparam logic [XW-1:0] NEG_LIM = POS_LIM + XW'(1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_CHK,
		ST_MAGN,
		ST_MAGD,
		ST_GCD,
		ST_GSHL,
		ST_DIVN,
		ST_DIVD,
		ST_FIN
	} state_t;

	state_t                  st_q;
	rau_pkg::action_t        act_q;
	logic signed [OB-1:0]    an_q, ad_q, bn_q, bd_q;
	logic signed [AW-1:0]    num_q, den_q;
	logic [MW-1:0]           nmag_q, dmag_q, x_q, y_q, g_q, rem_q, q_q, qn_q;
	logic [CNW-1:0]          cnt_q;
	logic                    neg_q, err_q, zero_q;
	logic                    out_valid_q, out_status_q;
	logic signed [NOB-1:0]   out_num_q;
	logic [DOB-1:0]          out_den_q;

	logic signed [OB-1:0]    mul_a, mul_b;
	logic signed [PW-1:0]    prod_s1;
	logic signed [AW-1:0]    prod_ext;
	rau_pkg::alu_op_t        alu_op;
	logic [AW-1:0]           alu_a, alu_b, alu_res;
	logic                    div_ge;
	logic [MW-1:0]           rem_nxt, q_nxt, mag_nxt;
	logic                    out_free;
	logic [XW-1:0]           ext_n, ext_d;
	logic                    over;
	logic [NOB-1:0]          fin_mag;
	logic signed [NOB-1:0]   fin_num;

	rau_mul #(
		.OPERAND_BITS(OB)
	) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (prod_s1)
	);

	rau_alu #(
		.WIDTH(AW)
	) u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	assign prod_ext = {prod_s1[PW-1], prod_s1};

	always_comb begin
		mul_a = an_q;
		mul_b = bd_q;
		unique case (st_q)
			ST_MUL0: begin
				mul_a = an_q;
				mul_b = (act_q == rau_pkg::ACT_MUL) ? bn_q : bd_q;
			end
			ST_MUL1: begin
				mul_a = ad_q;
				mul_b = (act_q == rau_pkg::ACT_DIV) ? bn_q : bd_q;
			end
			ST_MUL2: begin
				mul_a = bn_q;
				mul_b = ad_q;
			end
			default: begin
				mul_a = an_q;
				mul_b = bd_q;
			end
		endcase
	end

	always_comb begin
		alu_op = rau_pkg::ALU_SUB;
		alu_a  = '0;
		alu_b  = '0;
		unique case (st_q)
			ST_MUL3: begin
				alu_op = (act_q == rau_pkg::ACT_SUB) ? rau_pkg::ALU_SUB : rau_pkg::ALU_ADD;
				alu_a  = num_q;
				alu_b  = prod_ext;
			end
			ST_MAGN: begin
				alu_b = num_q;
			end
			ST_MAGD: begin
				alu_b = den_q;
			end
			ST_GCD: begin
				alu_a = {1'b0, x_q};
				alu_b = {1'b0, y_q};
			end
			ST_DIVN, ST_DIVD: begin
				alu_a = {rem_q, q_q[MW-1]};
				alu_b = {1'b0, g_q};
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	assign div_ge  = !alu_res[AW-1];
	assign rem_nxt = div_ge ? alu_res[MW-1:0] : {rem_q[MW-2:0], q_q[MW-1]};
	assign q_nxt   = {q_q[MW-2:0], div_ge};
	assign mag_nxt = alu_res[MW-1:0];

	assign ext_n   = XW'(qn_q);
	assign ext_d   = XW'(q_q);
	assign over    = (ext_d > DEN_LIM) || (neg_q ? (ext_n > NEG_LIM) : (ext_n > POS_LIM));
	assign fin_mag = ext_n[NOB-1:0];
	assign fin_num = neg_q ? NOB'(NOB'(0) - fin_mag) : fin_mag;

	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			act_q        <= rau_pkg::ACT_ADD;
			an_q         <= '0;
			ad_q         <= '0;
			bn_q         <= '0;
			bd_q         <= '0;
			num_q        <= '0;
			den_q        <= '0;
			nmag_q       <= '0;
			dmag_q       <= '0;
			x_q          <= '0;
			y_q          <= '0;
			g_q          <= '0;
			rem_q        <= '0;
			q_q          <= '0;
			qn_q         <= '0;
			cnt_q        <= '0;
			neg_q        <= 1'b0;
			err_q        <= 1'b0;
			zero_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= 1'b0;
			out_num_q    <= '0;
			out_den_q    <= '0;
		end else begin
			if (out_valid_q && rsp.ready && st_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (req.valid) begin
						act_q  <= rau_pkg::action_t'(req.action);
						an_q   <= req.a_numerator;
						ad_q   <= req.a_denominator;
						bn_q   <= req.b_numerator;
						bd_q   <= req.b_denominator;
						err_q  <= 1'b0;
						zero_q <= 1'b0;
						st_q   <= ST_MUL0;
					end
				end
				ST_MUL0: begin
					st_q <= ST_MUL1;
				end
				ST_MUL1: begin
					num_q <= prod_ext;
					st_q  <= ST_MUL2;
				end
				ST_MUL2: begin
					den_q <= prod_ext;
					st_q  <= ST_MUL3;
				end
				ST_MUL3: begin
					if (act_q == rau_pkg::ACT_ADD || act_q == rau_pkg::ACT_SUB) begin
						num_q <= alu_res;
					end
					st_q <= ST_CHK;
				end
				ST_CHK: begin
					priority if (den_q == '0) begin
						err_q <= 1'b1;
						st_q  <= ST_FIN;
					end else if (num_q == '0) begin
						zero_q <= 1'b1;
						st_q   <= ST_FIN;
					end else begin
						neg_q <= num_q[AW-1] ^ den_q[AW-1];
						st_q  <= ST_MAGN;
					end
				end
				ST_MAGN: begin
					nmag_q <= num_q[AW-1] ? mag_nxt : num_q[MW-1:0];
					x_q    <= num_q[AW-1] ? mag_nxt : num_q[MW-1:0];
					st_q   <= ST_MAGD;
				end
				ST_MAGD: begin
					dmag_q <= den_q[AW-1] ? mag_nxt : den_q[MW-1:0];
					y_q    <= den_q[AW-1] ? mag_nxt : den_q[MW-1:0];
					cnt_q  <= '0;
					st_q   <= ST_GCD;
				end
				ST_GCD: begin
					priority if (x_q == '0) begin
						g_q  <= y_q;
						st_q <= ST_GSHL;
					end else if (y_q == '0) begin
						g_q  <= x_q;
						st_q <= ST_GSHL;
					end else if (!x_q[0] && !y_q[0]) begin
						x_q   <= x_q >> 1;
						y_q   <= y_q >> 1;
						cnt_q <= cnt_q + CNW'(1);
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (alu_res[AW-1]) begin
						x_q <= y_q;
						y_q <= x_q;
					end else begin
						x_q <= alu_res[MW-1:0];
					end
				end
				ST_GSHL: begin
					if (cnt_q == '0) begin
						rem_q <= '0;
						q_q   <= nmag_q;
						cnt_q <= CNW'(MW);
						st_q  <= ST_DIVN;
					end else begin
						g_q   <= g_q << 1;
						cnt_q <= cnt_q - CNW'(1);
					end
				end
				ST_DIVN: begin
					if (cnt_q == CNW'(1)) begin
						qn_q  <= q_nxt;
						rem_q <= '0;
						q_q   <= dmag_q;
						cnt_q <= CNW'(MW);
						st_q  <= ST_DIVD;
					end else begin
						rem_q <= rem_nxt;
						q_q   <= q_nxt;
						cnt_q <= cnt_q - CNW'(1);
					end
				end
				ST_DIVD: begin
					rem_q <= rem_nxt;
					q_q   <= q_nxt;
					cnt_q <= cnt_q - CNW'(1);
					if (cnt_q == CNW'(1)) begin
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						priority if (err_q || (!zero_q && over)) begin
							out_num_q    <= '0;
							out_den_q    <= '0;
							out_status_q <= 1'b1;
						end else if (zero_q) begin
							out_num_q    <= '0;
							out_den_q    <= DOB'(1);
							out_status_q <= 1'b0;
						end else begin
							out_num_q    <= fin_num;
							out_den_q    <= ext_d[DOB-1:0];
							out_status_q <= 1'b0;
						end
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready              = (st_q == ST_IDLE);
	assign rsp.valid              = out_valid_q;
	assign rsp.result_numerator   = out_num_q;
	assign rsp.result_denominator = out_den_q;
	assign rsp.status             = out_status_q;

	`RAU_ASSERT_IMPL(a_err_fields_zero, clk, arst_n, rsp.valid && rsp.status,
		rsp.result_numerator == '0 && rsp.result_denominator == '0)
	`RAU_ASSERT_IMPL(a_zero_num_unit_den, clk, arst_n,
		rsp.valid && !rsp.status && rsp.result_numerator == '0, rsp.result_denominator == DOB'(1))
	`RAU_ASSERT_IMPL(a_ok_den_nonzero, clk, arst_n, rsp.valid && !rsp.status,
		rsp.result_denominator != '0)
	`RAU_ASSERT_IMPL(a_gcd_operand_live, clk, arst_n, st_q == ST_GCD, x_q != '0 || y_q != '0)
	`RAU_ASSERT_IMPL(a_div_exact, clk, arst_n,
		(st_q == ST_DIVN || st_q == ST_DIVD) && cnt_q == CNW'(1), rem_nxt == '0)

endmodule
